@@ sv/tcw_pkg.sv @@
// shared types and codes for the text console writer
// no dependencies
package tcw_pkg;

	typedef struct packed {
		logic [7:0] color;
		logic [7:0] chr;
	} cell_t;

	localparam logic [1:0] ACT_PUT   = 2'd0;
	localparam logic [1:0] ACT_READ  = 2'd1;
	localparam logic [1:0] ACT_SET   = 2'd2;
	localparam logic [1:0] ACT_CLEAR = 2'd3;

	localparam logic [7:0] CH_NUL   = 8'd0;
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'd32;

endpackage

@@ sv/tcw_cell_ram.sv @@
// cell store: one write port and one read port with registered read data
// depends on tcw_pkg
module tcw_cell_ram #(
	parameter int DEPTH = 2000,
	parameter int AW    = 11
) (
	input  logic                clk,
	input  logic                we,
	input  logic [AW-1:0]       waddr,
	input  tcw_pkg::cell_t      wdata,
	input  logic [AW-1:0]       raddr,
	output tcw_pkg::cell_t      rdata
);

	tcw_pkg::cell_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ sv/text_console_writer_unit.sv @@
// text console writer: cursor sequencer over a rows-by-columns cell store
// depends on tcw_pkg and tcw_cell_ram
// path to the output register: put without scroll loads it when accepted, read cell passes S_READ,
// set cursor passes S_ROWB (column found by repeated subtract of COLUMNS),
// scroll passes S_SCROLL, S_DRAIN and S_FILL, clear passes S_FILL; next transfer once idle and not stalled
// after reset a clearing pass zeroes the store, no transfer taken
module text_console_writer_unit #(
	parameter int ROWS    = 25,
	parameter int COLUMNS = 80
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [7:0]  character,
	input  logic [7:0]  color,
	input  logic [10:0] position,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  cell_char,
	output logic [7:0]  cell_color,
	output logic [10:0] cursor_cell,
	output logic        scrolled
);

	localparam int CELLS = ROWS * COLUMNS;
	localparam int AW    = $clog2(CELLS);
	localparam int CW    = $clog2(COLUMNS);

	localparam logic [AW-1:0] LAST   = AW'(CELLS - 1);
	localparam logic [AW-1:0] BOT    = AW'(CELLS - COLUMNS);
	localparam logic [AW-1:0] COLS_A = AW'(COLUMNS);
	localparam logic [CW-1:0] COL_END = CW'(COLUMNS - 1);

	localparam logic [2:0] S_INIT   = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_READ   = 3'd2;
	localparam logic [2:0] S_ROWB   = 3'd3;
	localparam logic [2:0] S_SCROLL = 3'd4;
	localparam logic [2:0] S_DRAIN  = 3'd5;
	localparam logic [2:0] S_FILL   = 3'd6;

	logic [2:0]      state_q;
	logic [AW-1:0]   cursor_q;
	logic [CW-1:0]   col_q;
	logic [AW-1:0]   ptr_q;
	logic [AW-1:0]   wptr_q;
	logic            pend_q;
	logic            scr_q;
	tcw_pkg::cell_t  fill_q;

	logic            out_valid_q;
	logic [7:0]      out_char_q;
	logic [7:0]      out_color_q;
	logic [AW-1:0]   out_cursor_q;
	logic            out_scr_q;

	logic            acc;
	logic [AW-1:0]   pos_c;
	logic [AW-1:0]   rowb;
	logic            we;
	logic [AW-1:0]   waddr;
	tcw_pkg::cell_t  wdata;
	logic [AW-1:0]   raddr;
	tcw_pkg::cell_t  rdata;

	assign in_stall = (state_q != S_IDLE) || (out_valid_q && out_stall);
	assign acc      = in_valid && !in_stall;
	assign pos_c    = (32'(position) >= 32'(CELLS)) ? LAST : AW'(position);
	assign rowb     = cursor_q - AW'(col_q);
	assign raddr    = (state_q == S_SCROLL) ? ptr_q : pos_c;

	always_comb begin
		we    = 1'b0;
		waddr = wptr_q;
		wdata = fill_q;
		unique case (state_q)
			S_IDLE: begin
				if (acc && action == tcw_pkg::ACT_PUT && character != tcw_pkg::CH_NUL &&
				    character != tcw_pkg::CH_CR && character != tcw_pkg::CH_LF) begin
					we    = 1'b1;
					waddr = cursor_q;
					wdata = '{color: color, chr: character};
				end
			end
			S_SCROLL: begin
				we    = pend_q;
				wdata = rdata;
			end
			S_DRAIN: begin
				we    = 1'b1;
				wdata = rdata;
			end
			S_FILL: begin
				we = 1'b1;
			end
			S_INIT: begin
				we    = 1'b1;
				wdata = '0;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	tcw_cell_ram #(
		.DEPTH (CELLS),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			cursor_q    <= '0;
			col_q       <= '0;
			wptr_q      <= '0;
			ptr_q       <= '0;
			pend_q      <= 1'b0;
			scr_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// an accepted item decides the output valid itself
			if (out_valid_q && !out_stall && !acc) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_INIT: begin
					if (wptr_q == LAST) begin
						state_q <= S_IDLE;
					end else begin
						wptr_q <= wptr_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (acc) begin
						unique case (action)
							tcw_pkg::ACT_PUT: begin
								if (character == tcw_pkg::CH_NUL) begin
									out_valid_q  <= 1'b1;
									out_char_q   <= '0;
									out_color_q  <= '0;
									out_cursor_q <= cursor_q;
									out_scr_q    <= 1'b0;
								end else if (character == tcw_pkg::CH_CR) begin
									cursor_q     <= rowb;
									col_q        <= '0;
									out_valid_q  <= 1'b1;
									out_char_q   <= '0;
									out_color_q  <= '0;
									out_cursor_q <= rowb;
									out_scr_q    <= 1'b0;
								end else if (character == tcw_pkg::CH_LF && rowb != BOT) begin
									cursor_q     <= rowb + COLS_A;
									col_q        <= '0;
									out_valid_q  <= 1'b1;
									out_char_q   <= '0;
									out_color_q  <= '0;
									out_cursor_q <= rowb + COLS_A;
									out_scr_q    <= 1'b0;
								end else if (character != tcw_pkg::CH_LF && cursor_q != LAST) begin
									cursor_q     <= cursor_q + 1'b1;
									col_q        <= (col_q == COL_END) ? '0 : col_q + 1'b1;
									out_valid_q  <= 1'b1;
									out_char_q   <= '0;
									out_color_q  <= '0;
									out_cursor_q <= cursor_q + 1'b1;
									out_scr_q    <= 1'b0;
								end else begin
									// line feed on bottom row or write into last cell
									cursor_q    <= BOT;
									col_q       <= '0;
									ptr_q       <= COLS_A;
									wptr_q      <= '0;
									pend_q      <= 1'b0;
									scr_q       <= 1'b1;
									fill_q      <= '{color: color, chr: tcw_pkg::CH_SPACE};
									out_valid_q <= 1'b0;
									state_q     <= S_SCROLL;
								end
							end
							tcw_pkg::ACT_READ: begin
								out_valid_q <= 1'b0;
								state_q     <= S_READ;
							end
							tcw_pkg::ACT_SET: begin
								cursor_q    <= pos_c;
								ptr_q       <= pos_c;
								out_valid_q <= 1'b0;
								state_q     <= S_ROWB;
							end
							tcw_pkg::ACT_CLEAR: begin
								cursor_q    <= '0;
								col_q       <= '0;
								wptr_q      <= '0;
								scr_q       <= 1'b0;
								fill_q      <= '{color: color, chr: tcw_pkg::CH_SPACE};
								out_valid_q <= 1'b0;
								state_q     <= S_FILL;
							end
							default: begin
								out_valid_q <= 1'b0;
								state_q     <= S_IDLE;
							end
						endcase
					end
				end
				S_READ: begin
					out_valid_q  <= 1'b1;
					out_char_q   <= rdata.chr;
					out_color_q  <= rdata.color;
					out_cursor_q <= cursor_q;
					out_scr_q    <= 1'b0;
					state_q      <= S_IDLE;
				end
				S_ROWB: begin
					// column found by repeated subtract of one row width
					if (ptr_q >= COLS_A) begin
						ptr_q <= ptr_q - COLS_A;
					end else begin
						col_q        <= CW'(ptr_q);
						out_valid_q  <= 1'b1;
						out_char_q   <= '0;
						out_color_q  <= '0;
						out_cursor_q <= cursor_q;
						out_scr_q    <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				S_SCROLL: begin
					// read runs one row ahead, each write lands in the cycle after its read
					if (pend_q) begin
						wptr_q <= wptr_q + 1'b1;
					end
					pend_q <= 1'b1;
					if (ptr_q == LAST) begin
						state_q <= S_DRAIN;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				S_DRAIN: begin
					pend_q  <= 1'b0;
					wptr_q  <= wptr_q + 1'b1;
					state_q <= S_FILL;
				end
				S_FILL: begin
					if (wptr_q == LAST) begin
						out_valid_q  <= 1'b1;
						out_char_q   <= '0;
						out_color_q  <= '0;
						out_cursor_q <= cursor_q;
						out_scr_q    <= scr_q;
						state_q      <= S_IDLE;
					end else begin
						wptr_q <= wptr_q + 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign cell_char   = out_char_q;
	assign cell_color  = out_color_q;
	assign cursor_cell = 11'(out_cursor_q);
	assign scrolled    = out_scr_q;

endmodule

@@ dv/tb.sv @@
// self-checking testbench for text_console_writer_unit (25 x 80 cell store)
// depends on tcw_pkg and the block's RTL; holds its own console predictor
// directed puts, reads, cursor sets, scrolls and clears, then random traffic with idling, then without
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ROWS        = 25;
	localparam int COLUMNS     = 80;
	localparam int CELLS       = ROWS * COLUMNS;
	localparam int CYCLE_LIMIT = 6_000_000;

	typedef struct packed {
		logic [7:0]  chr;
		logic [7:0]  color;
		logic [10:0] cursor;
		logic        scrolled;
	} console_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  action = tcw_pkg::ACT_PUT;
	logic [7:0]  character = 8'd0;
	logic [7:0]  color = 8'd0;
	logic [10:0] position = 11'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  cell_char;
	logic [7:0]  cell_color;
	logic [10:0] cursor_cell;
	logic        scrolled;

	// predictor state
	tcw_pkg::cell_t  screen [CELLS];
	int unsigned     cursor_pos;
	console_result_t pending_results [$];

	bit idling_on = 1'b1;
	int errors = 0;
	int cycles = 0;
	int stall_left = 0;

	text_console_writer_unit #(
		.ROWS(ROWS),
		.COLUMNS(COLUMNS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.character(character),
		.color(color),
		.position(position),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cell_char(cell_char),
		.cell_color(cell_color),
		.cursor_cell(cursor_cell),
		.scrolled(scrolled)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results outstanding", $time, pending_results.size());
			$display("[text_console_writer_unit] ERROR");
			$finish;
		end
	end

	// moves the cursor forward, scrolling once when it runs off the last cell
	function automatic bit advance_cursor(input int unsigned step, input logic [7:0] fill);
		int unsigned target;
		target = cursor_pos + step;
		if (target >= CELLS) begin
			for (int i = 0; i < CELLS - COLUMNS; i++)
				screen[i] = screen[i + COLUMNS];
			for (int i = CELLS - COLUMNS; i < CELLS; i++)
				screen[i] = '{color: fill, chr: tcw_pkg::CH_SPACE};
			cursor_pos = target - COLUMNS;
			return 1'b1;
		end
		cursor_pos = target;
		return 1'b0;
	endfunction

	function automatic void predict_console(input logic [1:0] act, input logic [7:0] ch,
			input logic [7:0] col, input logic [10:0] pos);
		console_result_t res;
		int unsigned idx;
		res = '0;
		idx = (pos >= CELLS) ? CELLS - 1 : pos;
		case (act)
			tcw_pkg::ACT_PUT: begin
				if (ch == tcw_pkg::CH_CR) begin
					cursor_pos = (cursor_pos / COLUMNS) * COLUMNS;
				end else if (ch == tcw_pkg::CH_LF) begin
					cursor_pos = (cursor_pos / COLUMNS) * COLUMNS;
					res.scrolled = advance_cursor(COLUMNS, col);
				end else if (ch != tcw_pkg::CH_NUL) begin
					screen[cursor_pos] = '{color: col, chr: ch};
					res.scrolled = advance_cursor(1, col);
				end
			end
			tcw_pkg::ACT_READ: begin
				res.chr   = screen[idx].chr;
				res.color = screen[idx].color;
			end
			tcw_pkg::ACT_SET: begin
				cursor_pos = idx;
			end
			default: begin
				for (int i = 0; i < CELLS; i++)
					screen[i] = '{color: col, chr: tcw_pkg::CH_SPACE};
				cursor_pos = 0;
			end
		endcase
		res.cursor = cursor_pos[10:0];
		pending_results.push_back(res);
	endfunction

	// payload stays put until the transfer; valid stays high between back-to-back items
	task automatic send_item(input logic [1:0] act, input logic [7:0] ch,
			input logic [7:0] col, input logic [10:0] pos);
		if (idling_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		action    <= act;
		character <= ch;
		color     <= col;
		position  <= pos;
		do @(posedge clk); while (in_stall);
		predict_console(act, ch, col, pos);
	endtask

	always @(posedge clk) begin : result_check
		console_result_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					$display({"%0t: unexpected result: expected none, ",
						"actual char %0h color %0h cursor %0d scrolled %0b"},
						$time, cell_char, cell_color, cursor_cell, scrolled);
					errors++;
				end else begin
					want = pending_results.pop_front();
					if (cell_char !== want.chr) begin
						$display("%0t: cell_char expected %0h actual %0h", $time, want.chr, cell_char);
						errors++;
					end
					if (cell_color !== want.color) begin
						$display("%0t: cell_color expected %0h actual %0h", $time, want.color,
							cell_color);
						errors++;
					end
					if (cursor_cell !== want.cursor) begin
						$display("%0t: cursor_cell expected %0d actual %0d", $time, want.cursor,
							cursor_cell);
						errors++;
					end
					if (scrolled !== want.scrolled) begin
						$display("%0t: scrolled expected %0b actual %0b", $time, want.scrolled,
							scrolled);
						errors++;
					end
				end
			end
			if (stall_left == 0 && idling_on && $urandom_range(0, 5) == 0)
				stall_left = $urandom_range(1, 8);
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic test_put_controls();
		send_item(tcw_pkg::ACT_PUT, 8'h41, 8'h07, 11'd0);
		send_item(tcw_pkg::ACT_PUT, 8'hFF, 8'hFF, 11'd2047);
		send_item(tcw_pkg::ACT_PUT, tcw_pkg::CH_NUL, 8'h12, 11'd5);
		send_item(tcw_pkg::ACT_PUT, tcw_pkg::CH_CR, 8'h34, 11'd0);
		send_item(tcw_pkg::ACT_PUT, tcw_pkg::CH_LF, 8'h00, 11'd0);
		send_item(tcw_pkg::ACT_READ, 8'h00, 8'h00, 11'd0);
		send_item(tcw_pkg::ACT_READ, 8'hFF, 8'hFF, 11'd1);
		send_item(tcw_pkg::ACT_READ, 8'h00, 8'h00, 11'd2047);
	endtask

	task automatic test_cursor_and_scroll();
		// clamp to the last cell, then a put there scrolls
		send_item(tcw_pkg::ACT_SET, 8'h00, 8'h00, 11'd2047);
		send_item(tcw_pkg::ACT_PUT, 8'h01, 8'h80, 11'd0);
		send_item(tcw_pkg::ACT_READ, 8'h00, 8'h00, 11'd1999);
		send_item(tcw_pkg::ACT_READ, 8'h00, 8'h00, 11'd1919);
		// line feed on the bottom row
		send_item(tcw_pkg::ACT_SET, 8'h00, 8'h00, 11'd1920);
		send_item(tcw_pkg::ACT_PUT, tcw_pkg::CH_LF, 8'h3C, 11'd0);
		send_item(tcw_pkg::ACT_SET, 8'h00, 8'h00, 11'd2000);
		send_item(tcw_pkg::ACT_PUT, tcw_pkg::CH_CR, 8'h00, 11'd0);
		send_item(tcw_pkg::ACT_SET, 8'h00, 8'h00, 11'd1000);
		send_item(tcw_pkg::ACT_PUT, tcw_pkg::CH_CR, 8'h00, 11'd0);
		send_item(tcw_pkg::ACT_PUT, tcw_pkg::CH_LF, 8'h00, 11'd0);
	endtask

	task automatic test_clear();
		send_item(tcw_pkg::ACT_CLEAR, 8'hFF, 8'hAA, 11'd1234);
		send_item(tcw_pkg::ACT_READ, 8'h00, 8'h00, 11'd1234);
		send_item(tcw_pkg::ACT_PUT, 8'h7F, 8'h55, 11'd0);
		send_item(tcw_pkg::ACT_READ, 8'h00, 8'h00, 11'd0);
		send_item(tcw_pkg::ACT_READ, 8'h00, 8'h00, 11'd1999);
	endtask

	// mostly text runs; cursor sets lean toward the bottom row so scrolls are common
	task automatic test_random_traffic(input int count);
		int unsigned r;
		logic [1:0]  act;
		logic [7:0]  ch;
		logic [10:0] pos;
		for (int n = 0; n < count; n++) begin
			r   = $urandom_range(0, 99);
			ch  = 8'($urandom_range(0, 255));
			pos = 11'($urandom_range(0, 2047));
			if (r < 70) begin
				act = tcw_pkg::ACT_PUT;
				r = $urandom_range(0, 19);
				if (r < 2)
					ch = tcw_pkg::CH_LF;
				else if (r == 2)
					ch = tcw_pkg::CH_CR;
				else if (r == 3)
					ch = tcw_pkg::CH_NUL;
			end else if (r < 82) begin
				act = tcw_pkg::ACT_READ;
			end else if (r < 97) begin
				act = tcw_pkg::ACT_SET;
				if ($urandom_range(0, 1) == 0)
					pos = 11'($urandom_range(1900, 2047));
			end else begin
				act = tcw_pkg::ACT_CLEAR;
			end
			send_item(act, ch, 8'($urandom_range(0, 255)), pos);
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		cursor_pos = 0;
		for (int i = 0; i < CELLS; i++)
			screen[i] = '0;
		@(posedge clk);
		test_put_controls();
		test_cursor_and_scroll();
		test_clear();
		test_random_traffic(580);
		idling_on = 1'b0;
		test_random_traffic(45);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0) begin
			$display("[text_console_writer_unit] OK");
		end else begin
			$display("[text_console_writer_unit] ERROR");
		end
		$finish;
	end

endmodule
